// ===== src/ita_pkg.sv =====
// Package for the radix text converter: widths, character codes, register map
// and the control bundle between the top level and the digit row.
// No dependencies.
package ita_pkg;

    // Default sizes handed to the top level parameters.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_CHARS_DEF   = 32;

    // Radix register.
    localparam int              RADIX_W      = 6;
    localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
    localparam logic [RADIX_W-1:0] SIGNED_RADIX = 6'd10;

    // Configuration port geometry and register indexes.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_RADIX = 1'b0;

    // Character codes.
    localparam int CHAR_W = 7;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_LOW_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2d;
    localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

    // Control handed from the sequencer to the digit row.
    typedef struct packed {
        logic clear;
        logic step;
        logic bit_in;
    } t_chain_ctrl;

    // Clamp a written radix into the supported range.
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [PDATA_W-1:0] wdata);
        logic [RADIX_W-1:0] v;
        v = wdata[RADIX_W-1:0];
        if (v < RADIX_MIN) begin
            v = RADIX_MIN;
        end else if (v > RADIX_MAX) begin
            v = RADIX_MAX;
        end
        return v;
    endfunction

    // Map a digit value to its lower-case ASCII character.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_DIGITS) begin
            c = ASCII_ZERO + {1'b0, d};
        end else begin
            c = ASCII_LOW_A + {1'b0, d - DECIMAL_DIGITS};
        end
        return c;
    endfunction

endpackage

// ===== src/ita_if.sv =====
// Request channel interfaces for the radix text converter.
// Depends on ita_pkg for the default value width and the character width.
interface ita_in_if #(
    parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface ita_out_if;
    logic                          valid;
    logic                          ready;
    logic [ita_pkg::CHAR_W-1:0]    character;
    logic                          last_char;

    modport source (output valid, output character, output last_char, input ready);
    modport sink   (input valid, input character, input last_char, output ready);
endinterface

// ===== src/ita_digit_cell.sv =====
// One digit of the conversion row: holds a digit in the current radix and
// doubles it plus the carry from below each step. Depends on ita_pkg.
module ita_digit_cell (
    input  logic                           i_clk,
    input  logic                           i_clear,
    input  logic                           i_step,
    input  logic                           i_carry,
    input  logic [ita_pkg::RADIX_W-1:0]    i_radix,
    output logic                           o_carry,
    output logic [ita_pkg::RADIX_W-1:0]    o_digit
);

    logic [ita_pkg::RADIX_W-1:0] r_digit;
    logic [ita_pkg::RADIX_W-1:0] n_digit;
    logic [ita_pkg::RADIX_W:0]   w_twice;
    logic [ita_pkg::RADIX_W:0]   w_radix;
    logic [ita_pkg::RADIX_W:0]   w_sum;
    logic [ita_pkg::RADIX_W:0]   w_diff;
    logic                        w_ge_even;
    logic                        w_ge_odd;

    // Carry out is decided locally except for the incoming carry, so the
    // row ripples only through one AND-OR per cell.
    always_comb begin
        w_twice   = {r_digit, 1'b0};
        w_radix   = {1'b0, i_radix};
        w_sum     = {r_digit, i_carry};
        w_ge_even = (w_twice >= w_radix);
        w_ge_odd  = ({r_digit, 1'b1} >= w_radix);
        o_carry   = w_ge_even | (i_carry & w_ge_odd);
        w_diff    = w_sum - w_radix;
        n_digit   = o_carry ? w_diff[ita_pkg::RADIX_W-1:0]
                            : w_sum[ita_pkg::RADIX_W-1:0];
    end

    // Digit register; a clear starts a new value at zero.
    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= '0;
        end else if (i_step) begin
            r_digit <= n_digit;
        end
    end

    assign o_digit = r_digit;

endmodule

// ===== src/ita_chain.sv =====
// Row of digit cells plus the count of significant digits.
// Depends on ita_pkg and ita_digit_cell.
module ita_chain #(
    parameter int NCELL = ita_pkg::VALUE_WIDTH_DEF,
    localparam int LEN_W = $clog2(NCELL + 1),
    localparam int IDX_W = $clog2(NCELL)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ita_pkg::t_chain_ctrl         i_ctrl,
    input  logic [ita_pkg::RADIX_W-1:0]  i_radix,
    input  logic [IDX_W-1:0]             i_rd_idx,
    output logic [ita_pkg::RADIX_W-1:0]  o_rd_digit,
    output logic [LEN_W-1:0]             o_len
);

    logic [NCELL:0]                      w_carry;
    logic [ita_pkg::RADIX_W-1:0]         w_digit [NCELL];
    logic [LEN_W-1:0]                    r_len;
    logic [LEN_W-1:0]                    n_len;
    logic [LEN_W-1:0]                    w_top;

    assign w_carry[0] = i_ctrl.bit_in;

    // The row: each cell passes its carry to the next one up.
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ita_digit_cell u_cell (
            .i_clk   (i_clk),
            .i_clear (i_ctrl.clear),
            .i_step  (i_ctrl.step),
            .i_carry (w_carry[g]),
            .i_radix (i_radix),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g])
        );
    end

    // Length grows by one when the top significant cell carries out.
    always_comb begin
        w_top = r_len - LEN_W'(1);
        n_len = r_len;
        if (i_ctrl.clear) begin
            n_len = LEN_W'(1);
        end else if (i_ctrl.step && (r_len < LEN_W'(NCELL))) begin
            n_len = r_len + LEN_W'(w_carry[w_top[IDX_W-1:0] + IDX_W'(1)]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
        end else begin
            r_len <= n_len;
        end
    end

    assign o_len      = r_len;
    assign o_rd_digit = w_digit[i_rd_idx];

endmodule

// ===== src/integer_to_ascii_radix.sv =====
// Top level of the radix text converter: configuration port, sequencer and
// output register. Depends on ita_pkg, ita_if and ita_chain.
//
//   channel   direction  carries                     accepted when
//   i_in      in         value                       valid && ready
//   o_out     out        character, last_char        valid && ready
//   apb       in/out     radix register at address 0 psel && penable && pwrite
//
// A request is loaded, then its VALUE_WIDTH bits pass through the digit row at one
// input bit per cycle, then the characters go out as the sink is ready for them.
// A new request is taken once the last character sits in the output register.
// Reset is synchronous and active low; it sets the radix to ten and idles.
// A stalled sink holds the current character and pauses character output.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = ita_pkg::VALUE_WIDTH_DEF,
    parameter int MAX_CHARS   = ita_pkg::MAX_CHARS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ita_in_if.sink                        i_in,
    ita_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ita_pkg::PADDR_W-1:0]   paddr,
    input  logic [ita_pkg::PDATA_W-1:0]   pwdata,
    output logic [ita_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int LEN_W  = $clog2(VALUE_WIDTH + 1);
    localparam int IDX_W  = $clog2(VALUE_WIDTH);
    localparam int BIT_W  = $clog2(VALUE_WIDTH);
    localparam int EMIT_W = $clog2(MAX_CHARS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } t_state;

    t_state                         r_state,      n_state;
    logic [ita_pkg::RADIX_W-1:0]    r_radix,      n_radix;
    logic [VALUE_WIDTH-1:0]         r_mag,        n_mag;
    logic [BIT_W-1:0]               r_bit_cnt,    n_bit_cnt;
    logic                           r_sign,       n_sign;
    logic [LEN_W-1:0]               r_dig_cnt,    n_dig_cnt;
    logic [EMIT_W-1:0]              r_emit_cnt,   n_emit_cnt;
    logic                           r_out_valid,  n_out_valid;
    logic [ita_pkg::CHAR_W-1:0]     r_out_char,   n_out_char;
    logic                           r_out_last,   n_out_last;

    ita_pkg::t_chain_ctrl           w_ctrl;
    logic [LEN_W-1:0]               w_len;
    logic [LEN_W-1:0]               w_idx;
    logic [ita_pkg::RADIX_W-1:0]    w_digit;
    logic                           w_in_take;
    logic                           w_load;
    logic                           w_last;
    logic                           w_neg;
    logic                           w_cfg_wr;

    // Digit row.
    ita_chain #(
        .NCELL (VALUE_WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_radix    (r_radix),
        .i_rd_idx   (w_idx[IDX_W-1:0]),
        .o_rd_digit (w_digit),
        .o_len      (w_len)
    );

    // Configuration port: single radix register, no wait states.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == ita_pkg::REG_RADIX);
    assign prdata   = {{(ita_pkg::PDATA_W - ita_pkg::RADIX_W){1'b0}}, r_radix};

    // Handshake and row control.
    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_load     = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);
    assign w_neg      = (r_radix == ita_pkg::SIGNED_RADIX) && i_in.value[VALUE_WIDTH-1];
    assign w_idx      = w_len - LEN_W'(1) - r_dig_cnt;

    always_comb begin
        w_ctrl.clear  = w_in_take;
        w_ctrl.step   = (r_state == S_CONV);
        w_ctrl.bit_in = r_mag[VALUE_WIDTH-1];
    end

    // Last character: end of the digits or the character limit.
    assign w_last = (!r_sign && (r_dig_cnt + LEN_W'(1) == w_len)) ||
                    (r_emit_cnt == EMIT_W'(MAX_CHARS - 1));

    // Sequencer next state.
    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_mag       = r_mag;
        n_bit_cnt   = r_bit_cnt;
        n_sign      = r_sign;
        n_dig_cnt   = r_dig_cnt;
        n_emit_cnt  = r_emit_cnt;
        n_out_valid = r_out_valid;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;

        if (w_cfg_wr) begin
            n_radix = ita_pkg::clamp_radix(pwdata);
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_take) begin
                    n_sign     = w_neg;
                    n_mag      = w_neg ? (~i_in.value + VALUE_WIDTH'(1)) : i_in.value;
                    n_bit_cnt  = '0;
                    n_dig_cnt  = '0;
                    n_emit_cnt = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                n_mag     = {r_mag[VALUE_WIDTH-2:0], 1'b0};
                n_bit_cnt = r_bit_cnt + BIT_W'(1);
                if (r_bit_cnt == BIT_W'(VALUE_WIDTH - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_out_last  = w_last;
                    n_emit_cnt  = r_emit_cnt + EMIT_W'(1);
                    if (r_sign) begin
                        n_out_char = ita_pkg::ASCII_MINUS;
                        n_sign     = 1'b0;
                    end else begin
                        n_out_char = ita_pkg::digit_char(w_digit);
                        n_dig_cnt  = r_dig_cnt + LEN_W'(1);
                    end
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= ita_pkg::RADIX_RESET;
            r_out_valid <= 1'b0;
            r_sign      <= 1'b0;
            r_bit_cnt   <= '0;
            r_dig_cnt   <= '0;
            r_emit_cnt  <= '0;
        end else begin
            r_state     <= n_state;
            r_radix     <= n_radix;
            r_out_valid <= n_out_valid;
            r_sign      <= n_sign;
            r_bit_cnt   <= n_bit_cnt;
            r_dig_cnt   <= n_dig_cnt;
            r_emit_cnt  <= n_emit_cnt;
        end
        r_mag      <= n_mag;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.character = r_out_char;
    assign o_out.last_char = r_out_last;

    // The stored radix never leaves the supported range.
    a_radix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix >= ita_pkg::RADIX_MIN) && (r_radix <= ita_pkg::RADIX_MAX))
        else $error("radix register out of range");

    // An accepted request always starts the bit conversion.
    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_take |=> (r_state == S_CONV) && (r_bit_cnt == '0))
        else $error("accepted request did not start conversion");

    // Digits emitted never pass the significant digit count.
    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_dig_cnt < w_len))
        else $error("digit index beyond significant digits");

    // A last character is followed by a return to idle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> (r_state == S_IDLE) && r_out_valid && r_out_last)
        else $error("final character did not end the request");

endmodule

// ===== tb/ita_text_checker.sv =====
`timescale 1ns / 1ps
// Checker for the radix text converter. It watches the value and character channels
// and the configuration port, predicts the text of each value and compares it.
// Depends on ita_pkg and the channel interfaces in ita_if.
module ita_text_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    ita_in_if                           i_value_mon,
    ita_out_if                          i_char_mon,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [ita_pkg::PADDR_W-1:0] i_paddr,
    input  logic [ita_pkg::PDATA_W-1:0] i_pwdata,
    input  logic [ita_pkg::PDATA_W-1:0] i_prdata,
    input  logic                        i_pready,
    output int                          o_errors,
    output int                          o_pending
);

    localparam logic [ita_pkg::PADDR_W-1:0] RADIX_ADDR =
        ita_pkg::PADDR_W'(4 * ita_pkg::REG_RADIX);
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [ita_pkg::CHAR_W-1:0] character;
        logic                       last_char;
    } t_char_result;

    // Characters still owed by the converter, oldest first.
    t_char_result                pending_chars[$];
    logic [ita_pkg::RADIX_W-1:0] radix_now;
    int                          mismatches = 0;

    assign o_errors = mismatches;

    // Print one line per mismatch, with the printing capped, and count it.
    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTED) begin
            $display("ita_text_checker: %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    // Queue the text of one value: a minus sign only in base ten, then the
    // digits most significant first. At the default sizes the text never
    // exceeds the character limit, so no truncation is needed.
    function automatic void predict_text(input logic [31:0] bits,
                                         input logic [ita_pkg::RADIX_W-1:0] base);
        logic [31:0]                 mag;
        logic [ita_pkg::RADIX_W-1:0] rem;
        logic [ita_pkg::CHAR_W-1:0]  rev_digits [0:31];
        int                          n;
        t_char_result                item;
        n = 0;
        mag = bits;
        if (base == ita_pkg::SIGNED_RADIX && bits[31]) begin
            mag = ~bits + 32'd1;
            item.character = ita_pkg::ASCII_MINUS;
            item.last_char = 1'b0;
            pending_chars.push_back(item);
        end
        do begin
            rem = ita_pkg::RADIX_W'(mag % base);
            if (rem < ita_pkg::DECIMAL_DIGITS) begin
                rev_digits[n] = ita_pkg::ASCII_ZERO + ita_pkg::CHAR_W'(rem);
            end else begin
                rev_digits[n] = ita_pkg::ASCII_LOW_A
                              + ita_pkg::CHAR_W'(rem - ita_pkg::DECIMAL_DIGITS);
            end
            n++;
            mag = mag / base;
        end while (mag != 0);
        for (int k = n - 1; k >= 0; k--) begin
            item.character = rev_digits[k];
            item.last_char = (k == 0);
            pending_chars.push_back(item);
        end
    endfunction

    // Track the radix, predict on each value request, compare each character.
    always @(posedge i_clk) begin
        t_char_result                want;
        logic [ita_pkg::RADIX_W-1:0] written;
        if (!i_rst_n) begin
            radix_now = ita_pkg::RADIX_RESET;
            pending_chars.delete();
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == RADIX_ADDR) begin
                if (i_pwrite) begin
                    written = i_pwdata[ita_pkg::RADIX_W-1:0];
                    if (written < ita_pkg::RADIX_MIN) begin
                        written = ita_pkg::RADIX_MIN;
                    end else if (written > ita_pkg::RADIX_MAX) begin
                        written = ita_pkg::RADIX_MAX;
                    end
                    radix_now = written;
                end else if (i_prdata !== ita_pkg::PDATA_W'(radix_now)) begin
                    report_mismatch($sformatf("radix read 0x%08h, want %0d",
                                              i_prdata, radix_now));
                end
            end
            if (i_value_mon.valid && i_value_mon.ready) begin
                predict_text(i_value_mon.value, radix_now);
            end
            if (i_char_mon.valid && i_char_mon.ready) begin
                if (pending_chars.size() == 0) begin
                    report_mismatch($sformatf("character 0x%02h with nothing expected",
                                              i_char_mon.character));
                end else begin
                    want = pending_chars.pop_front();
                    if (i_char_mon.character !== want.character) begin
                        report_mismatch($sformatf("character 0x%02h, want 0x%02h",
                                                  i_char_mon.character, want.character));
                    end
                    if (i_char_mon.last_char !== want.last_char) begin
                        report_mismatch($sformatf("last_char %b, want %b",
                                                  i_char_mon.last_char, want.last_char));
                    end
                end
            end
        end
        o_pending <= pending_chars.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the radix text converter: clock, reset, value and
// radix stimulus, output back-pressure, watchdog and verdict.
// Depends on ita_pkg, ita_if, integer_to_ascii_radix and ita_text_checker.
module tb_top;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 500;
    localparam int DRAIN_CYCLES   = 80;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 28;
    localparam logic [ita_pkg::PADDR_W-1:0] RADIX_ADDR =
        ita_pkg::PADDR_W'(4 * ita_pkg::REG_RADIX);

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [ita_pkg::PADDR_W-1:0] paddr;
    logic [ita_pkg::PDATA_W-1:0] pwdata;
    logic [ita_pkg::PDATA_W-1:0] prdata;
    logic                        pready;
    int                          errors;
    int                          pending;
    int                          stall_cycles;
    bit                          idle_on = 1'b1;
    bit                          sink_hold_req = 1'b0;

    ita_in_if  in_ch ();
    ita_out_if out_ch ();

    integer_to_ascii_radix dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ita_text_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value_mon (in_ch),
        .i_char_mon  (out_ch),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_prdata    (prdata),
        .i_pready    (pready),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
            stall_cycles <= 0;
        end else if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Character sink: random ready bursts, one long hold-off on request.
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                sink_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Offer one value request, sometimes after an idle burst, and wait for it.
    task automatic send_value(input logic [31:0] v);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every expected character has come out.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [ita_pkg::PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= RADIX_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Values weighted toward small numbers and the ends of the range.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0:       v = $urandom_range(0, 40);
            1:       v = -32'($urandom_range(1, 40));
            2:       v = 32'h7fff_ffff - $urandom_range(0, 3);
            3:       v = 32'h8000_0000 + $urandom_range(0, 3);
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // Radix writes: the extremes and base ten often, the rest random,
    // out-of-range and high-bit patterns included.
    function automatic logic [ita_pkg::PDATA_W-1:0] pick_radix();
        logic [ita_pkg::PDATA_W-1:0] d;
        case ($urandom_range(0, 5))
            0:       d = ita_pkg::PDATA_W'(ita_pkg::RADIX_MIN);
            1:       d = ita_pkg::PDATA_W'(ita_pkg::RADIX_MAX);
            2:       d = ita_pkg::PDATA_W'(ita_pkg::SIGNED_RADIX);
            3:       d = $urandom();
            4:       d = $urandom_range(0, 63);
            default: d = $urandom_range(2, 36);
        endcase
        return d;
    endfunction

    initial begin
        int phase;
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.value <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Base ten after reset: zero, the ends of the range, the most negative value.
        apb_access(1'b0, '0);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
        send_value(32'hffff_fff6);
        send_value(32'haaaa_aaaa);
        send_value(32'h5555_5555);

        // A write below the range lands on base two: full 32-digit text.
        wait_drained();
        apb_access(1'b1, 32'd0);
        apb_access(1'b0, '0);
        send_value(32'hffff_ffff);
        send_value(32'h8000_0000);
        send_value(32'd1);

        // A write above the range lands on base 36: the letters up to 'z'.
        wait_drained();
        apb_access(1'b1, 32'd37);
        apb_access(1'b0, '0);
        send_value(32'hffff_ffff);
        send_value(32'd35);
        send_value(32'd36);

        // Hexadecimal: negative patterns are plain unsigned here.
        wait_drained();
        apb_access(1'b1, 32'd16);
        apb_access(1'b0, '0);
        send_value(32'hdead_beef);
        send_value(32'h0123_abcd);

        wait_drained();
        apb_access(1'b1, 32'd1);
        apb_access(1'b0, '0);
        send_value(32'd0);

        // Only the low six bits of a write count: all ones clamps to 36.
        wait_drained();
        apb_access(1'b1, 32'hffff_ffff);
        apb_access(1'b0, '0);
        send_value(32'h7fff_ffff);

        // A neighbor of ten treats a negative value as unsigned.
        wait_drained();
        apb_access(1'b1, 32'd9);
        apb_access(1'b0, '0);
        send_value(32'h8000_0000);

        // Random phases, each with a new radix set while the converter is idle.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            apb_access(1'b1, (phase == 0) ? ita_pkg::PDATA_W'(ita_pkg::SIGNED_RADIX)
                                          : pick_radix());
            apb_access(1'b0, '0);
            if (phase == 2) begin
                sink_hold_req = 1'b1;
            end
            if (phase == RANDOM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            repeat (PHASE_ITEMS) send_value(pick_value());
        end

        wait_drained();
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
